[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define SSP_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ssp assertion failed");

// Condition that must hold in the cycle after the antecedent
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssp next-cycle assertion failed");

`endif

[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, widths and codes shared by the sparse set handle pool modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssp_pkg;

   // Pool size and derived widths
   localparam int CAPACITY    = 1024;
   localparam int HANDLE_W    = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int IN_HANDLE_W = 16;
   localparam int RANGE_W     = IN_HANDLE_W + 1;
   localparam int OUT_W       = 10;

   // Commands
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_CHECK  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]             command;
      logic [IN_HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] handle_out;
      logic [OUT_W-1:0] dense_index;
      logic             is_live;
      logic [1:0]       status;
   } rsp_type;

   // One table port: one write and one read per cycle
   typedef struct packed {
      logic                we;
      logic [HANDLE_W-1:0] waddr;
      logic [HANDLE_W-1:0] wdata;
      logic                re;
      logic [HANDLE_W-1:0] raddr;
   } ram_req_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic               busy;
      logic [COUNT_W-1:0] live;
      logic [COUNT_W-1:0] hwm;
   } seq_stat_type;

   // Handle or index to the fixed output field width
   function automatic logic [OUT_W-1:0] to_out(input logic [HANDLE_W-1:0] v);
      logic [OUT_W+HANDLE_W-1:0] t;
      t = {{OUT_W{1'b0}}, v};
      return t[OUT_W-1:0];
   endfunction

endpackage

[rtl/ssp_table_ram.sv]
// ----------------------------------------------------------------------------
// ssp_table_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_table_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ssp_seq.sv]
// ----------------------------------------------------------------------------
// ssp_seq
// Command sequencer: reads the sparse and dense tables, tests liveness,
// writes back the swap on free and keeps the live count and high-water mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_seq
   import ssp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output ram_req_type         dense_port,
   input  logic [HANDLE_W-1:0] dense_rdata,
   output ram_req_type         sparse_port,
   input  logic [HANDLE_W-1:0] sparse_rdata,
   input  logic                out_busy,
   output logic                res_load,
   output rsp_type             res_data,
   output seq_stat_type        stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_SWAP = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_W-1:0]     live_ff, live_in;
   logic [COUNT_W-1:0]     hwm_ff, hwm_in;
   logic [1:0]             cmd_ff;
   logic [IN_HANDLE_W-1:0] hdl_ff;
   logic [HANDLE_W-1:0]    addr_ff;
   logic [HANDLE_W-1:0]    last_ff, last_in;
   logic [HANDLE_W-1:0]    pos_ff, pos_in;

   logic                   accept;
   logic [COUNT_W-1:0]     live_dec;
   logic [HANDLE_W-1:0]    first_addr;
   logic [HANDLE_W-1:0]    hdl_addr;
   logic                   in_range;
   logic [HANDLE_W-1:0]    pos_dense;
   logic                   live_ok;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign live_dec = live_ff - COUNT_W'(1);
   assign hdl_addr = hdl_ff[HANDLE_W-1:0];
   assign in_range = RANGE_W'(hdl_ff) < RANGE_W'(CAPACITY);

   // Dense read on accept: slot at the live count for allocate, last live slot otherwise
   assign first_addr = (req_data.command == CMD_ALLOC) ? live_ff[HANDLE_W-1:0]
                                                       : live_dec[HANDLE_W-1:0];

   // Entries at or above the high-water mark were never written; their reset values are used instead
   always_comb begin
      last_in = (COUNT_W'(addr_ff) >= hwm_ff) ? addr_ff : dense_rdata;
      pos_in  = (COUNT_W'(hdl_addr) >= hwm_ff) ? '0 : sparse_rdata;
   end

   // Liveness test on the dense entry at the sparse position
   always_comb begin
      pos_dense = (COUNT_W'(pos_ff) >= hwm_ff) ? pos_ff : dense_rdata;
      live_ok   = in_range && (COUNT_W'(pos_ff) < live_ff)
                  && (IN_HANDLE_W'(pos_dense) == hdl_ff);
   end

   // Sequencing, table writes and result
   always_comb begin
      state_in    = state_ff;
      live_in     = live_ff;
      hwm_in      = hwm_ff;
      dense_port  = '0;
      sparse_port = '0;
      res_load    = 1'b0;
      res_data    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sparse_port.re    = 1'b1;
               sparse_port.raddr = req_data.handle_in[HANDLE_W-1:0];
               dense_port.re     = 1'b1;
               dense_port.raddr  = first_addr;
               state_in          = S_LOOK;
            end
         end
         S_LOOK: begin
            dense_port.re    = 1'b1;
            dense_port.raddr = pos_in;
            state_in         = S_EXEC;
         end
         S_EXEC: begin
            if (!out_busy) begin
               res_load = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (live_ff < COUNT_W'(CAPACITY)) begin
                        // Rewrite the slot so every entry below the mark holds real data
                        dense_port.we     = 1'b1;
                        dense_port.waddr  = live_ff[HANDLE_W-1:0];
                        dense_port.wdata  = last_ff;
                        sparse_port.we    = 1'b1;
                        sparse_port.waddr = last_ff;
                        sparse_port.wdata = live_ff[HANDLE_W-1:0];
                        live_in           = live_ff + COUNT_W'(1);
                        if (live_ff == hwm_ff) begin
                           hwm_in = hwm_ff + COUNT_W'(1);
                        end
                        res_data.handle_out = to_out(last_ff);
                     end else begin
                        res_data.status = ST_FULL;
                     end
                  end
                  CMD_FREE: begin
                     if (live_ok) begin
                        dense_port.we     = 1'b1;
                        dense_port.waddr  = pos_ff;
                        dense_port.wdata  = last_ff;
                        sparse_port.we    = 1'b1;
                        sparse_port.waddr = last_ff;
                        sparse_port.wdata = pos_ff;
                        live_in           = live_dec;
                        state_in          = S_SWAP;
                     end else begin
                        res_data.status = ST_INVALID;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (live_ok) begin
                        res_data.dense_index = to_out(pos_ff);
                     end else begin
                        res_data.status = ST_INVALID;
                     end
                  end
                  default: begin
                     res_data.is_live = live_ok;
                  end
               endcase
            end
         end
         S_SWAP: begin
            // Freed handle goes to the old last live slot
            dense_port.we    = 1'b1;
            dense_port.waddr = addr_ff;
            dense_port.wdata = hdl_addr;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         hwm_ff   <= '0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         hwm_ff   <= hwm_in;
      end
   end

   // Transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_data.command;
         hdl_ff  <= req_data.handle_in;
         addr_ff <= first_addr;
      end
      if (state_ff == S_LOOK) begin
         last_ff <= last_in;
         pos_ff  <= pos_in;
      end
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.live = live_ff;
   assign stat.hwm  = hwm_ff;

endmodule

[rtl/sparse_set_handle_pool_unit.sv]
// ----------------------------------------------------------------------------
// sparse_set_handle_pool_unit
// Handle allocator on a dense/sparse table pair with a live count.
// ----------------------------------------------------------------------------
// A transaction is accepted in idle, where it issues its reads, then passes
// through a look-up state to execute, which loads the result into the output
// register, waiting while that register still holds an unaccepted result.
// A successful free then adds a swap state, since its swap needs a second
// write into the dense table. The states follow the two dependent reads
// (sparse entry, then the dense entry at that position) through registered
// single-read-port tables. A new transaction is accepted once the previous
// one has finished, while its result may still wait in the output register.
// Reset takes effect at once: a high-water mark stands in for the reset
// contents of table entries never written, so no clearing pass is run.
`timescale 1ns / 1ps

module sparse_set_handle_pool_unit
   import ssp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   ram_req_type         dense_port;
   ram_req_type         sparse_port;
   logic [HANDLE_W-1:0] dense_rdata;
   logic [HANDLE_W-1:0] sparse_rdata;
   logic                out_busy;
   logic                res_load;
   rsp_type             res_data;
   seq_stat_type        stat;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   // Dense table: position -> handle
   ssp_table_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (HANDLE_W)
   ) u_dense (
      .clock (clock),
      .we    (dense_port.we),
      .waddr (dense_port.waddr),
      .wdata (dense_port.wdata),
      .re    (dense_port.re),
      .raddr (dense_port.raddr),
      .rdata (dense_rdata)
   );

   // Sparse table: handle -> position
   ssp_table_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (HANDLE_W)
   ) u_sparse (
      .clock (clock),
      .we    (sparse_port.we),
      .waddr (sparse_port.waddr),
      .wdata (sparse_port.wdata),
      .re    (sparse_port.re),
      .raddr (sparse_port.raddr),
      .rdata (sparse_rdata)
   );

   ssp_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .dense_port   (dense_port),
      .dense_rdata  (dense_rdata),
      .sparse_port  (sparse_port),
      .sparse_rdata (sparse_rdata),
      .out_busy     (out_busy),
      .res_load     (res_load),
      .res_data     (res_data),
      .stat         (stat)
   );

   // Output register
   assign out_busy     = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in = res_load || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `SSP_ASSERT(a_count_order, (stat.live <= stat.hwm) && (stat.hwm <= COUNT_W'(CAPACITY)))
   `SSP_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, stat.busy)
   `SSP_ASSERT(a_no_overwrite, !res_load || !out_busy)
   `SSP_ASSERT(a_live_ok, !rsp_valid || !rsp_data.is_live || (rsp_data.status == ST_OK))

endmodule

[verif/handle_pool_checker.sv]
// ----------------------------------------------------------------------------
// handle_pool_checker
// Watches both channels of the handle pool, predicts each result from its own
// copy of the dense/sparse tables and compares every result as it arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handle_pool_checker
   import ssp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      pending,
   output int      fail_count,
   output int      result_count,
   output int      full_count,
   output int      invalid_count
);

   // Predicted pool state
   logic [HANDLE_W-1:0] dense_slot [CAPACITY];
   logic [HANDLE_W-1:0] sparse_pos [CAPACITY];
   logic [COUNT_W-1:0]  live_total;

   // Results owed by the block, oldest first
   rsp_type owed_results [$];

   int fail_tally   = 0;
   int result_tally = 0;
   int full_tally   = 0;
   int invalid_tally = 0;

   assign fail_count    = fail_tally;
   assign result_count  = result_tally;
   assign full_count    = full_tally;
   assign invalid_count = invalid_tally;

   initial pending = 0;

   // Live: in range, sparse entry below the live count, and pointing back
   function automatic logic handle_live(input logic [IN_HANDLE_W-1:0] h);
      logic [HANDLE_W-1:0] p;
      if (h >= CAPACITY)
         return 1'b0;
      p = sparse_pos[h[HANDLE_W-1:0]];
      return (p < live_total) && (dense_slot[p] == h[HANDLE_W-1:0]);
   endfunction

   // Apply one transaction to the predicted state and return its result
   function automatic rsp_type predict_pool_result(input req_type r);
      rsp_type             res;
      logic [HANDLE_W-1:0] h;
      logic [HANDLE_W-1:0] pos;
      logic [HANDLE_W-1:0] last;
      logic [HANDLE_W-1:0] got;
      res = '0;
      h   = r.handle_in[HANDLE_W-1:0];
      case (r.command)
         CMD_ALLOC: begin
            if (live_total < CAPACITY) begin
               pos = live_total[HANDLE_W-1:0];
               got = dense_slot[pos];
               sparse_pos[got] = pos;
               live_total = live_total + 1'b1;
               res.handle_out = got;
            end else begin
               res.status = ST_FULL;
            end
         end
         CMD_FREE: begin
            // swap the last live handle into the freed slot
            if (handle_live(r.handle_in)) begin
               pos = sparse_pos[h];
               live_total = live_total - 1'b1;
               last = dense_slot[live_total[HANDLE_W-1:0]];
               dense_slot[live_total[HANDLE_W-1:0]] = h;
               sparse_pos[last] = pos;
               dense_slot[pos] = last;
            end else begin
               res.status = ST_INVALID;
            end
         end
         CMD_LOOKUP: begin
            if (handle_live(r.handle_in))
               res.dense_index = sparse_pos[h];
            else
               res.status = ST_INVALID;
         end
         CMD_CHECK: begin
            res.is_live = handle_live(r.handle_in);
         end
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_tally++;
      end
   endfunction

   // Compare results first, then queue the prediction for a new transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            dense_slot[i] = HANDLE_W'(i);
            sparse_pos[i] = '0;
         end
         live_total = '0;
         owed_results.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_tally++;
            if (owed_results.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fail_tally++;
            end else begin
               want = owed_results.pop_front();
               check_field("handle_out", want.handle_out, rsp_data.handle_out);
               check_field("dense_index", want.dense_index, rsp_data.dense_index);
               check_field("is_live", want.is_live, rsp_data.is_live);
               check_field("status", want.status, rsp_data.status);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_pool_result(req_data);
            if (want.status == ST_FULL)
               full_tally++;
            if (want.status == ST_INVALID)
               invalid_tally++;
            owed_results.push_back(want);
         end
         pending <= owed_results.size();
      end
   end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the handle pool with directed corner cases, a full fill and random
// command mixes under varying backpressure; the checker scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ssp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int pending;
   int fail_count;
   int result_count;
   int full_count;
   int invalid_count;

   // Stimulus knobs; receiver ones change by nonblocking assignment
   int send_idle   = 30;
   int rsp_idle    = 50;
   int hold_seq    = 0;
   int sent_by_cmd [4] = '{default: 0};
   int stall_cycles = 0;

   sparse_set_handle_pool_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   handle_pool_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .pending       (pending),
      .fail_count    (fail_count),
      .result_count  (result_count),
      .full_count    (full_count),
      .invalid_count (invalid_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      int hold_left;
      int hold_seen;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [1:0] cmd, input logic [IN_HANDLE_W-1:0] h);
      req_type item;
      item.command   = cmd;
      item.handle_in = h;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_by_cmd[cmd]++;
   endtask

   // Hold the input until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [1:0] pick_command(input int aw, input int fw, input int lw);
      int r;
      r = $urandom_range(0, 99);
      if (r < aw)
         return CMD_ALLOC;
      if (r < aw + fw)
         return CMD_FREE;
      if (r < aw + fw + lw)
         return CMD_LOOKUP;
      return CMD_CHECK;
   endfunction

   // Mostly in-range handles, some low ones, a few with any 16-bit value
   function automatic logic [IN_HANDLE_W-1:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return IN_HANDLE_W'($urandom_range(0, CAPACITY - 1));
      if (r < 92)
         return IN_HANDLE_W'($urandom_range(0, 15));
      return IN_HANDLE_W'($urandom());
   endfunction

   task automatic run_phase(input int n, input int s_idle, input int r_idle,
                            input int aw, input int fw, input int lw, input int hold_at);
      drain_results();
      send_idle = s_idle;
      rsp_idle <= r_idle;
      for (int k = 0; k < n; k++) begin
         if (k == hold_at)
            hold_seq <= hold_seq + 1;
         if (k == n / 2)
            drain_results();
         send_item(pick_command(aw, fw, lw), pick_handle());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pool: nothing is live
      send_item(CMD_CHECK, 16'd0);
      send_item(CMD_LOOKUP, 16'd0);
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_CHECK, 16'hFFFF);
      // First allocations; handle_in is ignored
      send_item(CMD_ALLOC, 16'hFFFF);
      send_item(CMD_ALLOC, 16'h0000);
      send_item(CMD_ALLOC, 16'hAAAA);
      send_item(CMD_LOOKUP, 16'd2);
      send_item(CMD_CHECK, 16'd1);
      // Free moves the last live handle into the hole
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_LOOKUP, 16'd2);
      send_item(CMD_CHECK, 16'd0);
      send_item(CMD_LOOKUP, 16'd0);
      send_item(CMD_FREE, 16'd0);
      // Out-of-range and never-allocated handles
      send_item(CMD_LOOKUP, 16'd1024);
      send_item(CMD_FREE, 16'h8000);
      send_item(CMD_CHECK, 16'd1024);
      send_item(CMD_FREE, 16'd1023);
      send_item(CMD_LOOKUP, 16'h5555);
      // Reuse of a freed handle, then back to empty
      send_item(CMD_ALLOC, 16'h5555);
      send_item(CMD_FREE, 16'd2);
      send_item(CMD_FREE, 16'd1);
      send_item(CMD_FREE, 16'd0);
      send_item(CMD_CHECK, 16'd2);

      // Fill the pool, then allocate past full
      drain_results();
      repeat (CAPACITY) send_item(CMD_ALLOC, IN_HANDLE_W'($urandom()));
      send_item(CMD_ALLOC, 16'd0);
      send_item(CMD_ALLOC, 16'hFFFF);
      send_item(CMD_LOOKUP, 16'd1023);
      send_item(CMD_FREE, 16'd1023);
      send_item(CMD_CHECK, 16'd1023);
      send_item(CMD_LOOKUP, 16'd0);

      // Random mixes: draining, refilling, balanced with a long output stall
      run_phase(670, 30, 50, 10, 50, 20, -1);
      run_phase(670, 50, 30, 45, 20, 15, -1);
      run_phase(670, 0, 0, 25, 30, 20, 300);

      drain_results();
      repeat (20) @(posedge clock);

      $display("Sent %0d transactions: %0d allocate, %0d free, %0d lookup, %0d check.",
               sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
               sent_by_cmd[CMD_ALLOC], sent_by_cmd[CMD_FREE],
               sent_by_cmd[CMD_LOOKUP], sent_by_cmd[CMD_CHECK]);
      $display("Compared %0d results, incl. %0d pool-full and %0d bad-handle responses.",
               result_count, full_count, invalid_count);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
